/* hw/rtl/ific_pkg.sv */
// Shared types, register map and sizing constants for the IRQ/FIQ interrupt controller.
// Used by ific_front, ific_back, the top level and the checker. No dependencies.
package ific_pkg;

  localparam int NUM_LINES   = 128;
  localparam int QUEUE_DEPTH = 128;
  localparam int LINE_W      = 7;
  localparam int LVL_W       = $clog2(NUM_LINES);
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QPTR_W      = QIDX_W + 1;
  localparam int BANK_BITS   = 128;

  localparam logic [31:0] REVISION_VALUE = 32'h50;
  localparam logic [9:0]  LEVEL_BASE     = 10'h100;
  localparam logic [10:0] LEVEL_END      = 11'(11'h100 + 4 * NUM_LINES);

  localparam logic [9:0] A_REVISION  = 10'h000;
  localparam logic [9:0] A_SYSCONFIG = 10'h010;
  localparam logic [9:0] A_SYSSTATUS = 10'h014;
  localparam logic [9:0] A_IRQ_VEC   = 10'h040;
  localparam logic [9:0] A_FIQ_VEC   = 10'h044;
  localparam logic [9:0] A_CONTROL   = 10'h048;
  localparam logic [9:0] A_PROTECT   = 10'h04c;
  localparam logic [9:0] A_IDLE      = 10'h050;
  localparam logic [9:0] A_PRIO0     = 10'h060;
  localparam logic [9:0] A_PRIO1     = 10'h064;
  localparam logic [9:0] A_THRESH    = 10'h068;

  localparam logic [4:0] B_RAW      = 5'h00;
  localparam logic [4:0] B_MASK     = 5'h04;
  localparam logic [4:0] B_MASK_CLR = 5'h08;
  localparam logic [4:0] B_MASK_SET = 5'h0c;
  localparam logic [4:0] B_SOFT_SET = 5'h10;
  localparam logic [4:0] B_SOFT_CLR = 5'h14;
  localparam logic [4:0] B_PEND_IRQ = 5'h18;
  localparam logic [4:0] B_PEND_FIQ = 5'h1c;

  localparam logic [31:0] ACK_IRQ = 32'd1;
  localparam logic [31:0] ACK_FIQ = 32'd2;
  localparam int SOFT_RESET_BIT = 1;

  typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_RAISE, OP_LOWER} opcode_t;
  typedef enum logic [1:0] {ST_OK, ST_BAD_ADDR, ST_MASKED, ST_QFULL} status_t;
  typedef enum logic [2:0] {
    K_READ, K_WRITE, K_RAISE, K_LOWER, K_BADLINE, K_ACK_IRQ, K_ACK_FIQ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [9:0]         address;
    logic [31:0]        write_data;
    logic [LINE_W-1:0]  line;
    logic               in_lvl;
    logic [LVL_W-1:0]   lvl_idx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

endpackage

/* hw/rtl/ific_front.sv */
// Front end: accepts input words, classifies them and holds them in a two-entry queue.
// Depends on ific_pkg.
module ific_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [9:0]          address,
  input  logic [31:0]         write_data,
  input  logic [6:0]          line_number,
  input  logic                pop,
  output ific_pkg::front_out_t head
);
  import ific_pkg::*;

  item_t      slot [2];
  item_t      dec;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       accept;
  logic [9:0] lvl_off;

  always_comb begin
    lvl_off        = address - LEVEL_BASE;
    dec.address    = address;
    dec.write_data = write_data;
    dec.line       = line_number;
    dec.in_lvl     = (address >= LEVEL_BASE) && ({1'b0, address} < LEVEL_END);
    dec.lvl_idx    = lvl_off[LVL_W+1:2];
    unique case (opcode_t'(opcode))
      OP_READ: dec.kind = K_READ;
      OP_WRITE: begin
        if (address == A_CONTROL && write_data == ACK_IRQ) dec.kind = K_ACK_IRQ;
        else if (address == A_CONTROL && write_data == ACK_FIQ) dec.kind = K_ACK_FIQ;
        else dec.kind = K_WRITE;
      end
      OP_RAISE: dec.kind = ({1'b0, line_number} >= 8'(NUM_LINES)) ? K_BADLINE : K_RAISE;
      default: dec.kind = ({1'b0, line_number} >= 8'(NUM_LINES)) ? K_BADLINE : K_LOWER;
    endcase
  end

  assign in_stall   = (count == 2'd2);
  assign accept     = in_valid && !in_stall;
  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (accept) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(accept) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slot[wr_ptr] <= dec;
  end

endmodule

/* hw/rtl/ific_back.sv */
// Back end: register file, level-word memory, IRQ queue and the sequencer that runs each word.
// Depends on ific_pkg; fed by ific_front.
module ific_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ific_pkg::front_out_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          read_data,
  output logic [1:0]           status,
  output logic                 irq_level,
  output logic                 fiq_level,
  output logic                 core_driven
);
  import ific_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_SERVE = 3'b100
  } state_t;

  state_t state, state_next;
  item_t  cur;

  logic [BANK_BITS-1:0] raw, raw_next, mask, mask_next;
  logic [BANK_BITS-1:0] pirq, pirq_next, pfiq, pfiq_next;
  logic [BANK_BITS-1:0] sset, sset_next, sclr, sclr_next;
  logic [31:0] irq_vec, irq_vec_next, fiq_vec, fiq_vec_next;
  logic [31:0] protect, protect_next, idle, idle_next, thresh, thresh_next;
  logic        reset_done, reset_done_next, active, active_next;
  logic [QPTR_W-1:0] q_head, q_head_next, q_tail, q_tail_next, q_cnt;
  logic        held_v, held_v_next;
  logic [LINE_W-1:0] held_line, held_line_next, srv_line, srv_line_next;
  logic        irq_o, irq_o_next, fiq_o, fiq_o_next;
  logic        out_valid_next;

  logic [31:0]       lvl_mem [NUM_LINES];
  logic [NUM_LINES-1:0] lvl_valid;
  logic [31:0]       lvl_q;
  logic              lvl_vq;
  logic              lvl_rd_en, lvl_we, lvl_clr;
  logic [LVL_W-1:0]  lvl_rd_addr;
  logic [LINE_W-1:0] q_mem [QUEUE_DEPTH];
  logic [LINE_W-1:0] q_q;
  logic              q_we;

  logic        out_free, fin, soft_rst, do_raise, do_lower, lvl_bit;
  logic [LINE_W-1:0] rl;
  logic [31:0] lvl_word, res_rd;
  status_t     res_st, raise_st;
  logic        res_drv;
  logic [1:0]  bank;
  logic [4:0]  boff;
  logic [6:0]  bsel;

  assign out_free = !out_valid || !out_stall;
  assign q_cnt    = q_tail - q_head;
  assign lvl_word = lvl_vq ? lvl_q : 32'd0;
  assign lvl_bit  = lvl_word[0];
  assign bank     = cur.address[6:5];
  assign boff     = cur.address[4:0];
  assign bsel     = {bank, 5'd0};

  always_comb begin
    state_next = state;      raw_next = raw;          mask_next = mask;
    pirq_next = pirq;        pfiq_next = pfiq;        sset_next = sset;
    sclr_next = sclr;        irq_vec_next = irq_vec;  fiq_vec_next = fiq_vec;
    protect_next = protect;  idle_next = idle;        thresh_next = thresh;
    reset_done_next = reset_done;  active_next = active;
    q_head_next = q_head;    q_tail_next = q_tail;    held_v_next = held_v;
    held_line_next = held_line;    srv_line_next = srv_line;
    irq_o_next = irq_o;      fiq_o_next = fiq_o;
    pop = 1'b0;  lvl_rd_en = 1'b0;  lvl_rd_addr = head.item.lvl_idx;
    lvl_we = 1'b0;  lvl_clr = 1'b0;  q_we = 1'b0;  fin = 1'b0;  soft_rst = 1'b0;
    do_raise = 1'b0;  do_lower = 1'b0;  rl = cur.line;
    res_rd = 32'd0;  res_st = ST_OK;  res_drv = 1'b0;  raise_st = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          lvl_rd_en = 1'b1;
          state_next = S_EXEC;
          case (head.item.kind)
            K_ACK_IRQ: lvl_rd_addr = irq_vec[LVL_W-1:0];
            K_ACK_FIQ: lvl_rd_addr = fiq_vec[LVL_W-1:0];
            K_RAISE, K_LOWER: lvl_rd_addr = head.item.line[LVL_W-1:0];
            default: lvl_rd_addr = head.item.lvl_idx;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          fin = 1'b1;
          unique case (cur.kind)
            K_READ: begin
              if (cur.in_lvl) begin
                res_rd = lvl_word;
              end else begin
                case (cur.address) inside
                  A_REVISION: res_rd = REVISION_VALUE;
                  A_SYSCONFIG, A_CONTROL, A_PRIO0, A_PRIO1: res_rd = 32'd0;
                  A_SYSSTATUS: res_rd = {31'd0, reset_done};
                  A_IRQ_VEC: res_rd = irq_vec;
                  A_FIQ_VEC: res_rd = fiq_vec;
                  A_PROTECT: res_rd = protect;
                  A_IDLE: res_rd = idle;
                  A_THRESH: res_rd = thresh;
                  default: begin
                    if (cur.address[9:7] == 3'b001) begin
                      case (boff) inside
                        B_RAW: res_rd = raw[bsel +: 32];
                        B_MASK: res_rd = mask[bsel +: 32];
                        B_MASK_CLR, B_MASK_SET, B_SOFT_CLR: res_rd = 32'd0;
                        B_SOFT_SET: res_rd = sset[bsel +: 32];
                        B_PEND_IRQ: res_rd = pirq[bsel +: 32];
                        B_PEND_FIQ: res_rd = pfiq[bsel +: 32];
                        default: res_st = ST_BAD_ADDR;
                      endcase
                    end else begin
                      res_st = ST_BAD_ADDR;
                    end
                  end
                endcase
              end
            end
            K_WRITE: begin
              if (cur.in_lvl) begin
                lvl_we = 1'b1;
              end else begin
                case (cur.address) inside
                  A_REVISION, A_SYSSTATUS, A_PRIO0, A_PRIO1, A_CONTROL: ;
                  A_SYSCONFIG: soft_rst = cur.write_data[SOFT_RESET_BIT];
                  A_IRQ_VEC: irq_vec_next = irq_vec & ~cur.write_data;
                  A_FIQ_VEC: fiq_vec_next = fiq_vec & ~cur.write_data;
                  A_PROTECT: protect_next = cur.write_data;
                  A_IDLE: idle_next = cur.write_data;
                  A_THRESH: thresh_next = cur.write_data;
                  default: begin
                    if (cur.address[9:7] == 3'b001) begin
                      case (boff) inside
                        B_RAW, B_PEND_IRQ, B_PEND_FIQ: ;
                        B_MASK: mask_next[bsel +: 32] = cur.write_data;
                        B_MASK_CLR: mask_next[bsel +: 32] = mask[bsel +: 32] & ~cur.write_data;
                        B_MASK_SET: mask_next[bsel +: 32] = mask[bsel +: 32] | cur.write_data;
                        B_SOFT_SET: sset_next[bsel +: 32] = cur.write_data;
                        B_SOFT_CLR: sclr_next[bsel +: 32] = cur.write_data;
                        default: res_st = ST_BAD_ADDR;
                      endcase
                    end else begin
                      res_st = ST_BAD_ADDR;
                    end
                  end
                endcase
              end
            end
            K_BADLINE: res_st = ST_BAD_ADDR;
            K_RAISE: do_raise = 1'b1;
            K_LOWER: do_lower = 1'b1;
            K_ACK_IRQ: begin
              do_lower = 1'b1;
              if (q_cnt != '0) begin
                fin           = 1'b0;
                q_head_next   = q_head + 1'b1;
                srv_line_next = q_q;
                lvl_rd_en     = 1'b1;
                lvl_rd_addr   = q_q[LVL_W-1:0];
                state_next    = S_SERVE;
              end
            end
            default: begin
              do_lower = 1'b1;
              if (held_v) begin
                fin           = 1'b0;
                held_v_next   = 1'b0;
                srv_line_next = held_line;
                lvl_rd_en     = 1'b1;
                lvl_rd_addr   = held_line[LVL_W-1:0];
                state_next    = S_SERVE;
              end
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          fin      = 1'b1;
          do_raise = 1'b1;
          rl       = srv_line;
          res_drv  = 1'b1;
        end
      end
    endcase

    if (do_lower) begin
      if (!lvl_bit) begin
        irq_o_next = 1'b1;
        irq_vec_next[LINE_W-1:0] = '0;
      end else begin
        fiq_o_next = 1'b1;
        fiq_vec_next[LINE_W-1:0] = '0;
      end
      active_next = 1'b0;
      res_drv     = 1'b1;
    end

    // A raise always sees registered state; an acknowledge commits its lower in S_EXEC first.
    if (do_raise) begin
      raw_next[rl] = 1'b1;
      if (mask[rl]) begin
        raise_st = ST_MASKED;
      end else if (!lvl_bit) begin
        if (active) begin
          if (q_cnt >= QPTR_W'(QUEUE_DEPTH)) begin
            raise_st = ST_QFULL;
          end else begin
            pirq_next[rl] = 1'b1;
            q_we          = 1'b1;
            q_tail_next   = q_tail + 1'b1;
          end
        end else begin
          irq_vec_next[LINE_W-1:0] = rl;
          irq_o_next    = 1'b0;
          fiq_o_next    = 1'b1;
          pirq_next[rl] = 1'b0;
          active_next   = 1'b1;
          res_drv       = 1'b1;
        end
      end else begin
        if (active) begin
          if (held_v) pfiq_next[held_line] = 1'b0;
          pfiq_next[rl]  = 1'b1;
          held_line_next = rl;
          held_v_next    = 1'b1;
        end else begin
          fiq_vec_next[LINE_W-1:0] = rl;
          irq_o_next    = 1'b1;
          fiq_o_next    = 1'b0;
          pfiq_next[rl] = 1'b0;
          active_next   = 1'b1;
          res_drv       = 1'b1;
        end
      end
      if (cur.kind == K_RAISE) res_st = raise_st;
    end

    if (soft_rst) begin
      raw_next = '0;  mask_next = '0;  pirq_next = '0;  pfiq_next = '0;
      sset_next = '0;  sclr_next = '0;  irq_vec_next = '0;  fiq_vec_next = '0;
      protect_next = '0;  idle_next = '0;  thresh_next = '0;
      reset_done_next = 1'b1;  active_next = 1'b0;
      q_head_next = '0;  q_tail_next = '0;  held_v_next = 1'b0;  held_line_next = '0;
      irq_o_next = 1'b1;  fiq_o_next = 1'b1;
      lvl_clr = 1'b1;  res_drv = 1'b1;
    end

    out_valid_next = out_valid && out_stall;
    if (fin) begin
      out_valid_next = 1'b1;
      state_next     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      raw <= '0;  mask <= '0;  pirq <= '0;  pfiq <= '0;  sset <= '0;  sclr <= '0;
      irq_vec <= '0;  fiq_vec <= '0;  protect <= '0;  idle <= '0;  thresh <= '0;
      reset_done <= 1'b0;  active <= 1'b0;  q_head <= '0;  q_tail <= '0;
      held_v <= 1'b0;  held_line <= '0;  irq_o <= 1'b1;  fiq_o <= 1'b1;
      lvl_valid <= '0;  out_valid <= 1'b0;
    end else begin
      state <= state_next;
      raw <= raw_next;  mask <= mask_next;  pirq <= pirq_next;  pfiq <= pfiq_next;
      sset <= sset_next;  sclr <= sclr_next;
      irq_vec <= irq_vec_next;  fiq_vec <= fiq_vec_next;
      protect <= protect_next;  idle <= idle_next;  thresh <= thresh_next;
      reset_done <= reset_done_next;  active <= active_next;
      q_head <= q_head_next;  q_tail <= q_tail_next;
      held_v <= held_v_next;  held_line <= held_line_next;
      irq_o <= irq_o_next;  fiq_o <= fiq_o_next;
      if (lvl_clr) lvl_valid <= '0;
      else if (lvl_we) lvl_valid[cur.lvl_idx] <= 1'b1;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head.item;
    srv_line <= srv_line_next;
    if (lvl_we) lvl_mem[cur.lvl_idx] <= cur.write_data;
    if (lvl_rd_en) begin
      lvl_q  <= lvl_mem[lvl_rd_addr];
      lvl_vq <= lvl_valid[lvl_rd_addr] && !rst;
    end
    if (q_we) q_mem[q_tail[QIDX_W-1:0]] <= rl;
    q_q <= q_mem[q_head[QIDX_W-1:0]];
    if (fin) begin
      read_data   <= res_rd;
      status      <= res_st;
      irq_level   <= irq_o_next;
      fiq_level   <= fiq_o_next;
      core_driven <= res_drv;
    end
  end

endmodule

/* hw/rtl/irq_fiq_interrupt_controller.sv */
// Top level of the vectored IRQ/FIQ interrupt controller.
// Instantiates ific_front and ific_back; depends on ific_pkg.
//
// Usage: each input word is a bus read, a bus write, a line raise or a line
// lower (opcode), with address, write_data and line_number alongside. Every
// word yields exactly one result word with read_data, status, the IRQ and FIQ
// core line levels after the word (0 is asserted) and core_driven.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The front end takes a word per cycle into a two-entry queue and stalls only
// when that queue is full. The back end runs one word at a time: a level-word
// memory read in S_IDLE, then execute in S_EXEC; a CONTROL acknowledge that
// serves a queued or held source adds S_SERVE for a second level-word read.
// Reset clears the register file and control state, releases both core lines
// and marks all level words as zero through per-line valid bits; the IRQ queue
// memory is not cleared and needs no clearing pass. While a result word is
// offered and out_stall is high, it holds and the back end waits; the front
// queue keeps taking words until full.
module irq_fiq_interrupt_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [9:0]  address,
  input  logic [31:0] write_data,
  input  logic [6:0]  line_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [1:0]  status,
  output logic        irq_level,
  output logic        fiq_level,
  output logic        core_driven
);
  import ific_pkg::*;

  front_out_t head;
  logic       pop;

  ific_front u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .address, .write_data, .line_number,
    .pop, .head
  );

  ific_back u_back (
    .clk, .rst, .head, .pop, .out_valid, .out_stall, .read_data, .status,
    .irq_level, .fiq_level, .core_driven
  );

endmodule

/* hw/rtl/ific_checker.sv */
// Port-level checks for the interrupt controller, bound to the top level.
// Depends on ific_pkg for status codes.
module ific_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic [9:0]  address,
  input logic [31:0] write_data,
  input logic [6:0]  line_number,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] read_data,
  input logic [1:0]  status,
  input logic        irq_level,
  input logic        fiq_level,
  input logic        core_driven
);
  import ific_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word present right after reset");

  // Both core lines are never asserted together.
  a_one_core_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_level || fiq_level))
    else $error("IRQ and FIQ asserted together");

  a_reject_no_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_MASKED || status == ST_QFULL) |-> !core_driven)
    else $error("masked or dropped raise drove the core lines");

  a_read_no_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 32'd0) |-> !core_driven)
    else $error("bus read drove the core lines");

endmodule

bind irq_fiq_interrupt_controller ific_port_checks u_checker (.*);

/* bench/ific_checker.sv */
// Checker for the IRQ/FIQ interrupt controller: watches both channels, predicts each
// result word from its own copy of the controller state and compares field by field.
// Depends on ific_pkg for opcodes, status codes and the register map.
module ific_checker
  import ific_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [9:0]  address,
  input  logic [31:0] write_data,
  input  logic [6:0]  line_number,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic [1:0]  status,
  input  logic        irq_level,
  input  logic        fiq_level,
  input  logic        core_driven,
  output int          errors,
  output int          outstanding
);

  typedef struct {
    logic [31:0] rdata;
    status_t     st;
    logic        irq;
    logic        fiq;
    logic        drv;
  } result_t;

  result_t expected_results[$];

  logic [31:0] raw_w [4];
  logic [31:0] mask_w [4];
  logic [31:0] pend_irq [4];
  logic [31:0] pend_fiq [4];
  logic [31:0] soft_set [4];
  logic [31:0] soft_clr [4];
  logic [31:0] level_w [128];
  logic [31:0] irq_vec, fiq_vec, protect_w, idle_w, thresh_w;
  logic        reset_done, active, held_valid, irq_line, fiq_line, drove;
  logic [6:0]  held_line;
  logic [6:0]  irq_fifo [128];
  logic [7:0]  q_head, q_tail;

  function automatic void clear_state();
    for (int i = 0; i < 4; i++) begin
      raw_w[i] = '0; mask_w[i] = '0; pend_irq[i] = '0; pend_fiq[i] = '0;
      soft_set[i] = '0; soft_clr[i] = '0;
    end
    for (int i = 0; i < 128; i++) level_w[i] = '0;
    irq_vec = '0; fiq_vec = '0; protect_w = '0; idle_w = '0; thresh_w = '0;
    reset_done = 0; active = 0; held_valid = 0; held_line = '0;
    q_head = '0; q_tail = '0; irq_line = 1; fiq_line = 1;
  endfunction

  function automatic status_t raise_source(input logic [6:0] ln);
    logic [1:0]  bank;
    logic [31:0] bit_m;
    logic [6:0]  old;
    bank = ln[6:5];
    bit_m = 32'd1 << ln[4:0];
    raw_w[bank] |= bit_m;
    if (mask_w[bank] & bit_m) return ST_MASKED;
    if (!level_w[ln][0]) begin
      if (active) begin
        if (8'(q_tail - q_head) >= QUEUE_DEPTH) return ST_QFULL;
        pend_irq[bank] |= bit_m;
        irq_fifo[q_tail[6:0]] = ln;
        q_tail = q_tail + 8'd1;
        return ST_OK;
      end
      irq_vec = {irq_vec[31:7], ln};
      irq_line = 0; fiq_line = 1;
      pend_irq[bank] &= ~bit_m;
    end else begin
      if (active) begin
        if (held_valid) begin
          old = held_line;
          pend_fiq[old[6:5]] &= ~(32'd1 << old[4:0]);
        end
        pend_fiq[bank] |= bit_m;
        held_line = ln;
        held_valid = 1;
        return ST_OK;
      end
      fiq_vec = {fiq_vec[31:7], ln};
      irq_line = 1; fiq_line = 0;
      pend_fiq[bank] &= ~bit_m;
    end
    active = 1;
    drove = 1;
    return ST_OK;
  endfunction

  function automatic void lower_source(input logic [6:0] ln);
    if (!level_w[ln][0]) begin
      irq_line = 1; irq_vec[6:0] = '0;
    end else begin
      fiq_line = 1; fiq_vec[6:0] = '0;
    end
    active = 0;
    drove = 1;
  endfunction

  function automatic status_t reg_read(input logic [9:0] a, output logic [31:0] v);
    v = '0;
    if (a >= LEVEL_BASE && 11'(a) < LEVEL_END) begin
      v = level_w[(a - LEVEL_BASE) >> 2];
      return ST_OK;
    end
    case (a)
      A_REVISION: begin v = REVISION_VALUE; return ST_OK; end
      A_SYSCONFIG, A_CONTROL, A_PRIO0, A_PRIO1: return ST_OK;
      A_SYSSTATUS: begin v = {31'd0, reset_done}; return ST_OK; end
      A_IRQ_VEC: begin v = irq_vec; return ST_OK; end
      A_FIQ_VEC: begin v = fiq_vec; return ST_OK; end
      A_PROTECT: begin v = protect_w; return ST_OK; end
      A_IDLE: begin v = idle_w; return ST_OK; end
      A_THRESH: begin v = thresh_w; return ST_OK; end
      default: ;
    endcase
    if (a >= 10'h80 && a < 10'h100) begin
      case (a[4:0])
        B_RAW: begin v = raw_w[a[6:5]]; return ST_OK; end
        B_MASK: begin v = mask_w[a[6:5]]; return ST_OK; end
        B_MASK_CLR, B_MASK_SET, B_SOFT_CLR: return ST_OK;
        B_SOFT_SET: begin v = soft_set[a[6:5]]; return ST_OK; end
        B_PEND_IRQ: begin v = pend_irq[a[6:5]]; return ST_OK; end
        B_PEND_FIQ: begin v = pend_fiq[a[6:5]]; return ST_OK; end
        default: ;
      endcase
    end
    return ST_BAD_ADDR;
  endfunction

  function automatic status_t reg_write(input logic [9:0] a, input logic [31:0] d);
    status_t     ignored;
    logic [6:0]  ln;
    if (a >= LEVEL_BASE && 11'(a) < LEVEL_END) begin
      level_w[(a - LEVEL_BASE) >> 2] = d;
      return ST_OK;
    end
    case (a)
      A_REVISION, A_SYSSTATUS, A_PRIO0, A_PRIO1: return ST_OK;
      A_SYSCONFIG: begin
        if (d[SOFT_RESET_BIT]) begin
          clear_state();
          reset_done = 1;
          drove = 1;
        end
        return ST_OK;
      end
      A_IRQ_VEC: begin irq_vec &= ~d; return ST_OK; end
      A_FIQ_VEC: begin fiq_vec &= ~d; return ST_OK; end
      A_CONTROL: begin
        if (d == ACK_IRQ) begin
          lower_source(irq_vec[6:0]);
          if (q_tail != q_head) begin
            ln = irq_fifo[q_head[6:0]];
            q_head = q_head + 8'd1;
            ignored = raise_source(ln);
          end
        end else if (d == ACK_FIQ) begin
          lower_source(fiq_vec[6:0]);
          if (held_valid) begin
            held_valid = 0;
            ignored = raise_source(held_line);
          end
        end
        return ST_OK;
      end
      A_PROTECT: begin protect_w = d; return ST_OK; end
      A_IDLE: begin idle_w = d; return ST_OK; end
      A_THRESH: begin thresh_w = d; return ST_OK; end
      default: ;
    endcase
    if (a >= 10'h80 && a < 10'h100) begin
      case (a[4:0])
        B_RAW, B_PEND_IRQ, B_PEND_FIQ: return ST_OK;
        B_MASK: begin mask_w[a[6:5]] = d; return ST_OK; end
        B_MASK_CLR: begin mask_w[a[6:5]] &= ~d; return ST_OK; end
        B_MASK_SET: begin mask_w[a[6:5]] |= d; return ST_OK; end
        B_SOFT_SET: begin soft_set[a[6:5]] = d; return ST_OK; end
        B_SOFT_CLR: begin soft_clr[a[6:5]] = d; return ST_OK; end
        default: ;
      endcase
    end
    return ST_BAD_ADDR;
  endfunction

  function automatic result_t predict_word(input opcode_t op, input logic [9:0] a,
                                           input logic [31:0] d, input logic [6:0] ln);
    result_t r;
    r.rdata = '0;
    drove = 0;
    case (op)
      OP_READ: r.st = reg_read(a, r.rdata);
      OP_WRITE: r.st = reg_write(a, d);
      OP_RAISE: r.st = (ln >= NUM_LINES) ? ST_BAD_ADDR : raise_source(ln);
      default: begin
        r.st = ST_OK;
        if (ln >= NUM_LINES) r.st = ST_BAD_ADDR;
        else lower_source(ln);
      end
    endcase
    r.irq = irq_line;
    r.fiq = fiq_line;
    r.drv = drove;
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    result_t exp_r;
    int      n_err;
    n_err = 0;
    if (rst) begin
      clear_state();
      expected_results.delete();
      errors <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_word(opcode_t'(opcode), address,
                                                write_data, line_number));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no word outstanding");
          n_err++;
        end else begin
          exp_r = expected_results.pop_front();
          if (read_data !== exp_r.rdata) begin
            $error("read_data expected %h actual %h", exp_r.rdata, read_data);
            n_err++;
          end
          if (status !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, status);
            n_err++;
          end
          if (irq_level !== exp_r.irq) begin
            $error("irq_level expected %b actual %b", exp_r.irq, irq_level);
            n_err++;
          end
          if (fiq_level !== exp_r.fiq) begin
            $error("fiq_level expected %b actual %b", exp_r.fiq, fiq_level);
            n_err++;
          end
          if (core_driven !== exp_r.drv) begin
            $error("core_driven expected %b actual %b", exp_r.drv, core_driven);
            n_err++;
          end
        end
      end
      errors <= errors + n_err;
    end
  end

endmodule

/* bench/irq_fiq_interrupt_controller_tb.sv */
// Top of the IRQ/FIQ interrupt controller testbench: clock, reset, directed and random
// bus and line words with idle and stall phases, watchdog and verdict.
// Depends on ific_pkg, ific_checker and the controller RTL.
module irq_fiq_interrupt_controller_tb;
  import ific_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 940;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [9:0]  address = '0;
  logic [31:0] write_data = '0;
  logic [6:0]  line_number = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] read_data;
  logic [1:0]  status;
  logic        irq_level, fiq_level, core_driven;
  int          errors, outstanding;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  irq_fiq_interrupt_controller DUT (.*);
  ific_checker u_scoreboard (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input opcode_t op, input logic [9:0] a,
                           input logic [31:0] d, input logic [6:0] ln);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    address <= a;
    write_data <= d;
    line_number <= ln;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [9:0] level_addr(input logic [6:0] ln);
    return LEVEL_BASE + 10'(ln) * 10'd4;
  endfunction

  function automatic logic [9:0] pick_addr();
    case ($urandom_range(9))
      0: return 10'($urandom);
      1, 2, 3: return level_addr(7'($urandom)) | 10'($urandom_range(3) == 0 ? $urandom_range(3) : 0);
      4, 5: return 10'h80 + 10'($urandom_range(3)) * 10'h20 + 10'($urandom_range(7)) * 10'd4;
      default: begin
        case ($urandom_range(10))
          0: return A_REVISION;
          1: return A_SYSSTATUS;
          2: return A_IRQ_VEC;
          3: return A_FIQ_VEC;
          4: return A_PROTECT;
          5: return A_IDLE;
          6: return A_PRIO0;
          7: return A_PRIO1;
          8: return A_THRESH;
          9: return A_CONTROL;
          default: return A_SYSCONFIG;
        endcase
      end
    endcase
  endfunction

  task automatic random_word();
    logic [9:0]  a;
    logic [31:0] d;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_word(OP_RAISE, '0, $urandom, 7'($urandom));
    end else if (pick < 52) begin
      send_word(OP_LOWER, '0, $urandom, 7'($urandom));
    end else if (pick < 64) begin
      send_word(OP_WRITE, A_CONTROL,
                $urandom_range(9) == 0 ? $urandom : ($urandom_range(2) == 0 ? ACK_FIQ : ACK_IRQ),
                7'($urandom));
    end else if (pick < 80) begin
      send_word(OP_READ, pick_addr(), $urandom, 7'($urandom));
    end else begin
      a = pick_addr();
      d = $urandom;
      // Keep masking sparse and soft resets rare so the queue can fill up.
      if (a >= 10'h80 && a < 10'h100 && (a[4:0] == B_MASK || a[4:0] == B_MASK_SET))
        d = d & $urandom & $urandom & $urandom;
      if (a == A_SYSCONFIG && $urandom_range(7) != 0) d[SOFT_RESET_BIT] = 0;
      if (a >= LEVEL_BASE && a < 10'h300) d[0] = ($urandom_range(3) == 0);
      send_word(OP_WRITE, a, d, 7'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed words.
    send_word(OP_READ, A_REVISION, '0, '0);
    send_word(OP_WRITE, level_addr(7'd127), 32'hffff_ffff, '0);
    send_word(OP_READ, level_addr(7'd127) | 10'd3, '0, '0);
    send_word(OP_RAISE, '0, '0, 7'd0);
    send_word(OP_RAISE, '0, '0, 7'd127);
    send_word(OP_WRITE, level_addr(7'd64), 32'd1, '0);
    send_word(OP_RAISE, '0, '0, 7'd64);
    send_word(OP_RAISE, '0, '0, 7'd5);
    send_word(OP_READ, 10'h80 + B_PEND_FIQ + 10'h60, '0, '0);
    send_word(OP_WRITE, A_CONTROL, 32'd7, '0);
    send_word(OP_WRITE, A_CONTROL, ACK_IRQ, '0);
    send_word(OP_WRITE, A_CONTROL, ACK_FIQ, '0);
    send_word(OP_WRITE, 10'h80 + B_MASK_SET, 32'h0000_0008, '0);
    send_word(OP_RAISE, '0, '0, 7'd3);
    send_word(OP_WRITE, 10'h80 + B_MASK_CLR, 32'hffff_ffff, '0);
    send_word(OP_WRITE, 10'h80 + B_SOFT_SET + 10'h20, 32'ha5a5_5a5a, '0);
    send_word(OP_READ, 10'h80 + B_SOFT_SET + 10'h20, '0, '0);
    send_word(OP_WRITE, 10'h80 + B_SOFT_CLR, 32'hffff_ffff, '0);
    send_word(OP_READ, 10'h80 + B_SOFT_CLR, '0, '0);
    send_word(OP_WRITE, 10'h80 + B_RAW, 32'hffff_ffff, '0);
    send_word(OP_READ, 10'h3fc, '0, '0);
    send_word(OP_WRITE, 10'h01c, 32'h1234_5678, '0);
    send_word(OP_LOWER, '0, '0, 7'd127);
    send_word(OP_WRITE, A_SYSCONFIG, 32'h2, '0);
    send_word(OP_READ, A_SYSSTATUS, '0, '0);

    // Random words in four phases of sender idling and receiver stalls.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case (n * 4 / RANDOM_WORDS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      // A burst of IRQ raises while a source is active drives the queue to full.
      if (n == 100) begin
        send_word(OP_WRITE, A_SYSCONFIG, 32'h2, '0);
        for (int k = 0; k < 135; k++) send_word(OP_RAISE, '0, '0, 7'($urandom));
        send_word(OP_WRITE, A_CONTROL, ACK_IRQ, '0);
        send_word(OP_RAISE, '0, '0, 7'($urandom));
      end
      random_word();
    end
    in_valid <= 0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
